// ----- sv/sampled_latency_percentile_monitor_core_assert.svh -----
// Assertion macros shared by the RTL files
`ifndef SAMPLED_LATENCY_PERCENTILE_MONITOR_CORE_ASSERT_SVH
`define SAMPLED_LATENCY_PERCENTILE_MONITOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define SLPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SLPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SLPM_ASSERT_IMP(lbl, ante, cons)
`define SLPM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/slpm_pkg.sv -----
`timescale 1ns / 1ps
package slpm_pkg;
  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned TsW = 64;
  localparam int unsigned LatW = 32;
  localparam int unsigned IvW = 16;
  localparam int unsigned NPct = 5;
  localparam int unsigned FracW = 10;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 8'd1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // rank fractions 1/2, 9/10, 19/20, 99/100, 999/1000
  function automatic logic [FracW-1:0] rank_num(input logic [2:0] p);
    logic [FracW-1:0] r;
    case (p)
      3'd0: r = 10'd1;
      3'd1: r = 10'd9;
      3'd2: r = 10'd19;
      3'd3: r = 10'd99;
      default: r = 10'd999;
    endcase
    return r;
  endfunction

  function automatic logic [FracW-1:0] rank_den(input logic [2:0] p);
    logic [FracW-1:0] r;
    case (p)
      3'd0: r = 10'd2;
      3'd1: r = 10'd10;
      3'd2: r = 10'd20;
      3'd3: r = 10'd100;
      default: r = 10'd1000;
    endcase
    return r;
  endfunction
endpackage

// ----- sv/slpm_ring.sv -----
`timescale 1ns / 1ps
module slpm_ring #(
  parameter int unsigned Capacity = slpm_pkg::CapacityDef,
  parameter int unsigned AddrW = $clog2(Capacity)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [slpm_pkg::LatW-1:0] wr_data_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [slpm_pkg::LatW-1:0] rd_data_o
);
  import slpm_pkg::*;

  logic [LatW-1:0] mem [Capacity];
  logic [LatW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule

// ----- sv/slpm_div.sv -----
`timescale 1ns / 1ps
module slpm_div #(
  parameter int unsigned DivW = 42
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);
  import slpm_pkg::*;
  `include "sampled_latency_percentile_monitor_core_assert.svh"

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW:0]   rem_q;
  logic [DivW-1:0] quo_q, dsr_q;
  logic [DivW:0]   shifted, diff;

  assign shifted = {rem_q[DivW-1:0], quo_q[DivW-1]};
  assign diff = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
          if (!diff[DivW]) begin
            rem_q <= diff;
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= shifted;
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quotient_o = quo_q;

  `SLPM_ASSERT_IMP(a_no_restart, start_i, !busy_q)
  `SLPM_ASSERT_IMP(a_done_idle, done_q, !busy_q)
  `SLPM_ASSERT_NXT(a_finish, busy_q && (cnt_q == '0), done_q)
endmodule

// ----- sv/sampled_latency_percentile_monitor_core.sv -----
`timescale 1ns / 1ps
// Record requests: one per cycle while idle; sampled ones are written to the ring at the accepting edge.
// Query requests: for n held latencies the time is set by the single ring read port (one
//   pass for the sum, one pass per entry for its rank) and the restoring divider for the
//   mean; an empty ring returns all zeros without a pass.
// Input not ready during a query or while a query result waits on the output.
// Async active-low reset: counters, phase and registers to defaults; ring contents undefined.
module sampled_latency_percentile_monitor_core #(
  parameter int unsigned Capacity = slpm_pkg::CapacityDef,
  parameter int unsigned CntW = $clog2(Capacity + 1),
  parameter int unsigned OutW = ((CntW + 6 * slpm_pkg::LatW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [2*slpm_pkg::TsW-1:0]   s_axis_tdata_i,  // receive_time, finish_time
  input  logic                         s_axis_tuser_i,  // op
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // sample_count, median_ns, pct90_ns, pct95_ns, pct99_ns, pct999_ns, mean_ns
  output logic [OutW-1:0]              m_axis_tdata_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [slpm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slpm_pkg::IvW-1:0]     cfg_data_i
);
  import slpm_pkg::*;
  `include "sampled_latency_percentile_monitor_core_assert.svh"

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned DivW = LatW + CntW;
  localparam int unsigned ProdW = CntW + FracW;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MDIV, S_MWAIT, S_ORD, S_OWAIT, S_INNER, S_CHECK
  } state_e;

  state_e          state_q;
  logic            en_q;
  logic [IvW-1:0]  intv_q, phase_q;
  logic [AddrW-1:0] widx_q;
  logic [CntW-1:0] fill_q, n_q, i_q, j_q, lt_q, le_q, cnt_out_q;
  logic [LatW-1:0] res_q [NPct];
  logic [LatW-1:0] mean_q, v_q;
  logic [DivW-1:0] sum_q;
  logic            pv_q, m_valid_q;

  logic            in_acc, rec_acc, q_acc, keep, wr_en;
  logic [TsW-1:0]  rx, fin, dlt;
  logic [LatW-1:0] lat, rd_data;
  logic [IvW-1:0]  intv_eff, phase_inc;
  logic [AddrW-1:0] rd_addr;
  logic            div_start, div_busy, div_done;
  logic [DivW-1:0] div_dividend, div_divisor, div_quo;
  logic [ProdW-1:0] rank_pos [NPct];
  logic [ProdW-1:0] rank_lo [NPct];
  logic [ProdW-1:0] rank_hi [NPct];

  assign rx = s_axis_tdata_i[TsW-1:0];
  assign fin = s_axis_tdata_i[2*TsW-1:TsW];
  assign dlt = fin - rx;
  assign lat = (fin <= rx) ? '0 : (|dlt[TsW-1:LatW]) ? '1 : dlt[LatW-1:0];

  assign s_axis_tready_o = (state_q == S_IDLE) && !m_valid_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign rec_acc = in_acc && (s_axis_tuser_i == OP_RECORD);
  assign q_acc = in_acc && (s_axis_tuser_i == OP_QUERY);
  assign keep = rec_acc && en_q && (phase_q == '0);
  assign wr_en = keep;
  assign intv_eff = (intv_q == '0) ? IvW'(1) : intv_q;
  assign phase_inc = phase_q + 1'b1;
  assign cfg_ready_o = (state_q == S_IDLE);

  assign rd_addr = (state_q == S_ORD) ? i_q[AddrW-1:0] : j_q[AddrW-1:0];

  // sorted position k is held by v when lt <= floor(n*num/den) < le
  always_comb begin
    for (int k = 0; k < NPct; k++) begin
      rank_pos[k] = ProdW'(n_q) * ProdW'(rank_num(3'(k)));
      rank_lo[k]  = ProdW'(lt_q) * ProdW'(rank_den(3'(k)));
      rank_hi[k]  = ProdW'(le_q) * ProdW'(rank_den(3'(k)));
    end
  end

  assign div_start = (state_q == S_MDIV);
  assign div_dividend = sum_q;
  assign div_divisor = DivW'(n_q);

  slpm_ring #(.Capacity(Capacity), .AddrW(AddrW)) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (widx_q),
    .wr_data_i (lat),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  slpm_div #(.DivW(DivW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      en_q      <= 1'b1;
      intv_q    <= IvW'(1);
      phase_q   <= '0;
      widx_q    <= '0;
      fill_q    <= '0;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      lt_q      <= '0;
      le_q      <= '0;
      cnt_out_q <= '0;
      mean_q    <= '0;
      v_q       <= '0;
      sum_q     <= '0;
      pv_q      <= 1'b0;
      m_valid_q <= 1'b0;
      for (int k = 0; k < NPct; k++) begin
        res_q[k] <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i && (cfg_index_i == CFG_INTERVAL)) begin
            phase_q <= '0;
          end else if (rec_acc && en_q) begin
            phase_q <= (phase_inc >= intv_eff) ? '0 : phase_inc;
          end
          if (keep) begin
            widx_q <= (widx_q == AddrW'(Capacity - 1)) ? '0 : widx_q + 1'b1;
            if (fill_q != CntW'(Capacity)) begin
              fill_q <= fill_q + 1'b1;
            end
          end
          if (q_acc) begin
            n_q <= fill_q;
            if (fill_q == '0) begin
              cnt_out_q <= '0;
              mean_q    <= '0;
              for (int k = 0; k < NPct; k++) begin
                res_q[k] <= '0;
              end
              m_valid_q <= 1'b1;
            end else begin
              j_q     <= '0;
              pv_q    <= 1'b0;
              sum_q   <= '0;
              state_q <= S_SUM;
            end
          end
          if (cfg_valid_i) begin
            if (cfg_index_i == CFG_ENABLE) begin
              en_q <= cfg_data_i[0];
            end else if (cfg_index_i == CFG_INTERVAL) begin
              intv_q <= cfg_data_i;
            end
          end
        end
        S_SUM: begin
          if (pv_q) begin
            sum_q <= sum_q + DivW'(rd_data);
          end
          if (j_q != n_q) begin
            j_q  <= j_q + 1'b1;
            pv_q <= 1'b1;
          end else begin
            pv_q <= 1'b0;
            if (!pv_q) begin
              state_q <= S_MDIV;
            end
          end
        end
        S_MDIV: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (div_done) begin
            mean_q  <= div_quo[LatW-1:0];
            i_q     <= '0;
            state_q <= S_ORD;
          end
        end
        S_ORD: state_q <= S_OWAIT;
        S_OWAIT: begin
          v_q     <= rd_data;
          j_q     <= '0;
          lt_q    <= '0;
          le_q    <= '0;
          pv_q    <= 1'b0;
          state_q <= S_INNER;
        end
        S_INNER: begin
          if (pv_q) begin
            if (rd_data < v_q) begin
              lt_q <= lt_q + 1'b1;
              le_q <= le_q + 1'b1;
            end else if (rd_data == v_q) begin
              le_q <= le_q + 1'b1;
            end
          end
          if (j_q != n_q) begin
            j_q  <= j_q + 1'b1;
            pv_q <= 1'b1;
          end else begin
            pv_q <= 1'b0;
            if (!pv_q) begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          for (int k = 0; k < NPct; k++) begin
            if ((rank_lo[k] <= rank_pos[k]) && (rank_pos[k] < rank_hi[k])) begin
              res_q[k] <= v_q;
            end
          end
          if (i_q + 1'b1 == n_q) begin
            cnt_out_q <= n_q;
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_ORD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = OutW'({mean_q, res_q[4], res_q[3], res_q[2], res_q[1], res_q[0],
                                 cnt_out_q});

  `SLPM_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CntW'(Capacity))
  `SLPM_ASSERT_IMP(a_wr_idle, wr_en, state_q == S_IDLE)
  `SLPM_ASSERT_IMP(a_div_free, div_start, !div_busy)
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import slpm_pkg::*;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned IdleLimit = 200000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_LAST = 8'hFF;

  typedef struct {
    logic [10:0] cnt;
    logic [31:0] med;
    logic [31:0] p90;
    logic [31:0] p95;
    logic [31:0] p99;
    logic [31:0] p999;
    logic [31:0] mean;
  } lat_stats_t;

  typedef struct {
    logic        op;
    logic [63:0] rx;
    logic [63:0] fin;
    logic        typed;
    lat_stats_t  stats;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [127:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [207:0] m_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [IvW-1:0] cfg_data = '0;

  lat_stats_t stats_q[$];
  logic [31:0] lat_ring [RingDepth];
  logic [15:0] phase;
  logic [9:0]  ring_wr;
  logic [10:0] ring_fill;
  logic        en_r;
  logic [15:0] iv_r;
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_go = 0;
  stim_row_t rows[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sampled_latency_percentile_monitor_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic int rank_idx(int n, int num, int den);
    int k;
    k = (n * num) / den;
    return (k >= n) ? n - 1 : k;
  endfunction

  function automatic lat_stats_t ring_stats();
    lat_stats_t r;
    logic [31:0] srt [RingDepth];
    logic [31:0] v;
    logic [63:0] sum;
    int n, j;
    r = '{default: '0};
    n = ring_fill;
    sum = 0;
    if (n == 0) return r;
    for (int i = 0; i < n; i++) begin
      v = lat_ring[i];
      sum += v;
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    r.cnt  = 11'(n);
    r.med  = srt[rank_idx(n, 1, 2)];
    r.p90  = srt[rank_idx(n, 9, 10)];
    r.p95  = srt[rank_idx(n, 19, 20)];
    r.p99  = srt[rank_idx(n, 99, 100)];
    r.p999 = srt[rank_idx(n, 999, 1000)];
    r.mean = 32'(sum / n);
    return r;
  endfunction

  function automatic void record_latency(logic [63:0] rx, logic [63:0] fin);
    logic keep;
    logic [15:0] iv;
    logic [31:0] lat;
    if (!en_r) return;
    iv = (iv_r == 0) ? 16'd1 : iv_r;
    keep = (phase == 0);
    phase = ((phase + 17'd1) >= iv) ? 16'd0 : phase + 16'd1;
    if (!keep) return;
    if (fin <= rx) lat = 0;
    else if (fin - rx > 64'hFFFF_FFFF) lat = 32'hFFFF_FFFF;
    else lat = 32'(fin - rx);
    lat_ring[ring_wr] = lat;
    ring_wr = ring_wr + 10'd1;
    if (ring_fill < RingDepth) ring_fill++;
  endfunction

  task automatic push_request(logic op, logic [63:0] rx, logic [63:0] fin,
                              logic typed = 0, lat_stats_t st = '{default: '0});
    bit ok;
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {fin, rx};
    do begin
      @(negedge clk);
      ok = s_ready;
      @(posedge clk);
    end while (!ok);
    if (op == OP_QUERY) stats_q.insert(stats_q.size(), typed ? st : ring_stats());
    else record_latency(rx, fin);
  endtask

  task automatic drain(int extra);
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (stats_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [IvW-1:0] val);
    bit ok;
    drain(5);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    if (idx == CFG_ENABLE) en_r = val[0];
    else if (idx == CFG_INTERVAL) begin
      iv_r = val;
      phase = 0;
    end
  endtask

  task automatic random_record();
    logic [63:0] rx, fin;
    rx = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: fin = {$urandom, $urandom};
      1: fin = rx - $urandom_range(0, 1000);
      2: fin = rx + {$urandom_range(0, 7), $urandom};
      default: fin = rx + $urandom_range(0, 5000);
    endcase
    push_request(OP_RECORD, rx, fin);
  endtask

  // receiver: stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_go = 0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        m_ready <= (mode == 0) || ($urandom_range(0, 3) >= mode);
      end
    end
  end

  always @(negedge clk) begin
    lat_stats_t e;
    logic [10:0] a_cnt;
    logic [31:0] a [6];
    if (m_valid && m_ready) begin
      a_cnt = m_data[10:0];
      for (int k = 0; k < 6; k++) a[k] = m_data[11 + 32*k +: 32];
      if (stats_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = stats_q.pop_front();
        if (a_cnt !== e.cnt) begin
          $error("sample_count exp %0d got %0d", e.cnt, a_cnt); errors++;
        end
        if (a[0] !== e.med) begin
          $error("median_ns exp %0d got %0d", e.med, a[0]); errors++;
        end
        if (a[1] !== e.p90) begin
          $error("pct90_ns exp %0d got %0d", e.p90, a[1]); errors++;
        end
        if (a[2] !== e.p95) begin
          $error("pct95_ns exp %0d got %0d", e.p95, a[2]); errors++;
        end
        if (a[3] !== e.p99) begin
          $error("pct99_ns exp %0d got %0d", e.p99, a[3]); errors++;
        end
        if (a[4] !== e.p999) begin
          $error("pct999_ns exp %0d got %0d", e.p999, a[4]); errors++;
        end
        if (a[5] !== e.mean) begin
          $error("mean_ns exp %0d got %0d", e.mean, a[5]); errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic stim_row_t row(logic op, logic [63:0] rx, logic [63:0] fin,
                                    logic typed = 0, lat_stats_t st = '{default: '0});
    stim_row_t r;
    r.op = op; r.rx = rx; r.fin = fin; r.typed = typed; r.stats = st;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    lat_stats_t all_max;
    en_r = 1; iv_r = 1; phase = 0; ring_wr = 0; ring_fill = 0;
    all_max = '{cnt: 11'd1, med: '1, p90: '1, p95: '1, p99: '1, p999: '1, mean: '1};
    add_row(row(OP_QUERY, '0, '0, 1, '{default: '0}));              // empty ring
    add_row(row(OP_RECORD, '0, '1));                                // saturates
    add_row(row(OP_QUERY, '0, '0, 1, all_max));
    add_row(row(OP_RECORD, '1, '0));                                // negative
    add_row(row(OP_RECORD, 64'h1234, 64'h1234));
    add_row(row(OP_RECORD, 64'd5, 64'd105));
    add_row(row(OP_RECORD, '1, '1));
    add_row(row(OP_RECORD, 64'd0, 64'hFFFF_FFFF));
    add_row(row(OP_RECORD, 64'd0, 64'h1_0000_0000));
    add_row(row(OP_QUERY, '1, '1));
    for (int k = 0; k < 8; k++) add_row(row(OP_RECORD, 64'd1000, 64'd1000 + 37 * k));
    add_row(row(OP_QUERY, '0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) push_request(rows[i].op, rows[i].rx, rows[i].fin,
                                   rows[i].typed, rows[i].stats);

    write_reg(CFG_ENABLE, 16'hFFFE);                                // disabled
    push_request(OP_RECORD, 64'd0, 64'd77);
    push_request(OP_QUERY, '0, '0);
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_INTERVAL, 16'd0);                                 // acts as one
    push_request(OP_RECORD, 64'd10, 64'd20);
    push_request(OP_RECORD, 64'd10, 64'd30);
    write_reg(CFG_SPARE, 16'd3);                                    // ignored
    write_reg(CFG_LAST, 16'd0);
    write_reg(CFG_INTERVAL, 16'hFFFF);
    push_request(OP_RECORD, 64'd0, 64'd999);
    push_request(OP_RECORD, 64'd0, 64'd888);
    push_request(OP_QUERY, '0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_reg(CFG_INTERVAL, 16'd1);
        2: write_reg(CFG_ENABLE, 16'($urandom & 16'hFFFE));
        3: write_reg(CFG_ENABLE, 16'($urandom | 16'h0001));
        default: write_reg(CFG_INTERVAL, 16'($urandom_range(10, 24)));
      endcase
      for (int k = 0; k < 80; k++) begin
        if (ph == 1 && k > 8) break;
        if ($urandom_range(0, 9) == 0) push_request(OP_QUERY, {$urandom, $urandom},
                                                    {$urandom, $urandom});
        else random_record();
        if (ph == 3 && k == 20) begin
          push_request(OP_QUERY, '0, '0);
          hold_go = 1;
          for (int q = 0; q < 10; q++) random_record();
        end
      end
      if (ph == 4) begin
        push_request(OP_QUERY, '0, '0);
        drain(0);
      end
    end

    drain(20);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
